>>> hdl/bvc_pkg.sv
package bvc_pkg;

  localparam int VOLT_W     = 23;
  localparam int CAP_W      = 7;
  localparam int IN_W       = 24;
  localparam int OUT_W      = 8;
  localparam int NUM_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 30;
  localparam int PROD_W     = VOLT_W + CAP_W;

  // One curve point as it sits in a point register.
  typedef struct packed {
    logic [CAP_W-1:0]  cap;
    logic [VOLT_W-1:0] volt;
  } point_t;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_BASE = 3'd1;

  localparam logic [NUM_W-1:0] MIN_POINTS = 3'd3;
  localparam logic [NUM_W-1:0] GEN_POINTS = 3'd3;
  localparam logic [CAP_W-1:0] FULL_CAP   = 7'd100;
  localparam logic [CAP_W-1:0] EMPTY_CAP  = 7'd0;

  // Fixed generic lithium curve used whenever the programmed curve is not usable.
  function automatic point_t gen_point(input logic [NUM_W-1:0] idx);
    point_t p;
    unique case (idx)
      3'd0:    p = '{cap: 7'd100, volt: 23'd4200000};
      3'd1:    p = '{cap: 7'd20,  volt: 23'd3600000};
      3'd2:    p = '{cap: 7'd0,   volt: 23'd3400000};
      default: p = '{cap: 7'd0,   volt: 23'd0};
    endcase
    return p;
  endfunction

endpackage

>>> hdl/battery_voltage_to_capacity.sv
// Battery fuel gauge: each request carries a voltage in microvolts and yields one result
// with the remaining capacity in percent, found by linear interpolation over a programmed
// discharge curve of 3 to MAX_POINTS points (falling voltages, capacity 100 at the first
// point and 0 at the last). A curve with a bad point count or end capacity is replaced by
// a fixed generic lithium curve (4.2 V, 3.6 V, 3.4 V at 100, 20, 0 percent); the voltage
// order is not checked. A negative voltage gives capacity 0 with the bad_input flag set.
// One request is worked on at a time: a new voltage is taken only after the last result
// has moved to the output register. A negative voltage skips the segment search, and one
// above the first point or below the last point ends it without the multiply and divide.
// The segment search reads one curve point per cycle, and the bit-serial multiply and
// restoring divide each work through the capacity bits one bit at a time.
// A finished result waits in the output register, so the next request is taken while it
// is still pending. Configuration writes go through cfg_we/cfg_index/cfg_wdata and must
// only be issued while the block is idle.
module battery_voltage_to_capacity #(
  parameter int MAX_POINTS = 6
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bvc_pkg::IN_W-1:0]        in_tdata,   // [23:0] voltage_uv (signed)
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bvc_pkg::OUT_W-1:0]       out_tdata,  // [6:0] capacity_percent, [7] bad_input
  input  logic                            cfg_we,
  input  logic [bvc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bvc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import bvc_pkg::*;

  localparam int IW = $clog2(MAX_POINTS);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  localparam logic [2:0] LAST_STEP = 3'(CAP_W - 1);

  logic [2:0]        state_r;
  logic [NUM_W-1:0]  num_r;
  point_t            pt_r [MAX_POINTS];

  logic [VOLT_W-1:0] v_r;        // voltage under test
  logic [IW-1:0]     i_r;        // lower point of the segment under test
  point_t            hi_r;       // upper point of the segment under test
  logic [CAP_W-1:0]  lo_cap_r;   // capacity at the lower point of the matched segment
  logic [VOLT_W-1:0] d_r;        // voltage above the lower point
  logic [PROD_W-1:0] dv_r;       // divisor, shifted right one place per divide step
  logic [PROD_W-1:0] acc_r;      // product, then running remainder
  logic [CAP_W-1:0]  sh_r;       // multiplier bits out, quotient bits in
  logic [2:0]        cnt_r;
  logic [CAP_W-1:0]  res_cap_r;
  logic              res_bad_r;
  logic [CAP_W-1:0]  out_cap_r;
  logic              out_bad_r;
  logic              out_valid_r;

  logic              last_zero;
  logic              curve_ok;
  logic [NUM_W-1:0]  n_eff;
  point_t            first_pt;
  point_t            cur_pt;
  logic              in_seg;
  logic              last_seg;
  logic [CAP_W-1:0]  cap_diff;
  logic [VOLT_W-1:0] volt_diff;
  logic [PROD_W-1:0] mul_nxt;
  logic              div_ge;
  logic [PROD_W-1:0] rem_nxt;
  logic [CAP_W-1:0]  quo_nxt;

  // The curve is usable when the point count is in range, it starts full and ends empty.
  always_comb begin
    last_zero = 1'b0;
    for (int k = 0; k < MAX_POINTS; k++) begin
      if (num_r == NUM_W'(k + 1)) begin
        last_zero = (pt_r[k].cap == EMPTY_CAP);
      end
    end
  end

  assign curve_ok = (num_r >= MIN_POINTS) && (num_r <= NUM_W'(MAX_POINTS)) &&
                    (pt_r[0].cap == FULL_CAP) && last_zero;
  assign n_eff    = curve_ok ? num_r : GEN_POINTS;
  assign first_pt = curve_ok ? pt_r[0] : gen_point('0);
  assign cur_pt   = curve_ok ? pt_r[i_r] : gen_point(NUM_W'(i_r));

  assign in_seg    = (v_r > cur_pt.volt) && (v_r <= hi_r.volt);
  assign last_seg  = (NUM_W'(i_r) == (n_eff - NUM_W'(1)));
  // A segment whose capacity rises toward lower voltage reads flat.
  assign cap_diff  = (hi_r.cap >= cur_pt.cap) ? (hi_r.cap - cur_pt.cap) : '0;
  assign volt_diff = hi_r.volt - cur_pt.volt;

  // Shift-and-add multiply, most significant multiplier bit first.
  assign mul_nxt = {acc_r[PROD_W-2:0], 1'b0} + (sh_r[CAP_W-1] ? PROD_W'(d_r) : '0);

  // Restoring divide: the quotient never exceeds the capacity difference, so seven
  // steps starting from the divisor shifted up by six places are enough.
  assign div_ge  = (acc_r >= dv_r);
  assign rem_nxt = div_ge ? (acc_r - dv_r) : acc_r;
  assign quo_nxt = {sh_r[CAP_W-2:0], div_ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      num_r       <= GEN_POINTS;
      for (int k = 0; k < MAX_POINTS; k++) begin
        pt_r[k] <= gen_point(NUM_W'(k));
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_NUM_POINTS) begin
          num_r <= cfg_wdata[NUM_W-1:0];
        end
        for (int k = 0; k < MAX_POINTS; k++) begin
          if (cfg_index == REG_POINT_BASE + CFG_IDX_W'(k)) begin
            pt_r[k] <= cfg_wdata;
          end
        end
      end

      // In the DONE state a taken result is replaced by the next one instead.
      if (out_valid_r && out_tready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            v_r       <= in_tdata[VOLT_W-1:0];
            hi_r      <= first_pt;
            i_r       <= IW'(1);
            res_cap_r <= '0;
            res_bad_r <= in_tdata[IN_W-1];
            state_r   <= in_tdata[IN_W-1] ? ST_DONE : ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (i_r == IW'(1) && v_r > hi_r.volt) begin
            res_cap_r <= FULL_CAP;
            state_r   <= ST_DONE;
          end else if (in_seg) begin
            lo_cap_r <= cur_pt.cap;
            d_r      <= v_r - cur_pt.volt;
            dv_r     <= PROD_W'(volt_diff) << (CAP_W - 1);
            sh_r     <= cap_diff;
            acc_r    <= '0;
            cnt_r    <= '0;
            state_r  <= ST_MUL;
          end else if (last_seg) begin
            res_cap_r <= EMPTY_CAP;
            state_r   <= ST_DONE;
          end else begin
            hi_r <= cur_pt;
            i_r  <= i_r + IW'(1);
          end
        end
        ST_MUL: begin
          acc_r <= mul_nxt;
          sh_r  <= {sh_r[CAP_W-2:0], 1'b0};
          cnt_r <= (cnt_r == LAST_STEP) ? '0 : cnt_r + 3'd1;
          if (cnt_r == LAST_STEP) begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          acc_r <= rem_nxt;
          sh_r  <= quo_nxt;
          dv_r  <= dv_r >> 1;
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == LAST_STEP) begin
            res_cap_r <= lo_cap_r + quo_nxt;
            state_r   <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_cap_r   <= res_cap_r;
            out_bad_r   <= res_bad_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_bad_r, out_cap_r};

endmodule

>>> hdl/bvc_checker.sv
module bvc_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [bvc_pkg::OUT_W-1:0] out_tdata
);
  import bvc_pkg::*;

  // A pending result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("pending result changed before it was taken");

  // A flagged input always reads empty.
  a_bad_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_W-1] |-> out_tdata[CAP_W-1:0] == EMPTY_CAP)
    else $error("bad_input result with nonzero capacity");

  // Only one request is in work at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again right after a request");

endmodule

bind battery_voltage_to_capacity bvc_checker u_bvc_checker (.*);
